>>> src/sdc_pkg.sv
// ----------------------------------------------------------------------------
// sdc_pkg
// Shared types and codes for the scaled decimal comparator.
// ----------------------------------------------------------------------------
`default_nettype none

package sdc_pkg;

  // Values of the order field of a result.
  localparam logic [1:0] ORD_LESS    = 2'd0;
  localparam logic [1:0] ORD_EQUAL   = 2'd1;
  localparam logic [1:0] ORD_GREATER = 2'd2;

  // Per-item control bits that travel alongside the datapath.
  typedef struct packed {
    logic swap;       // 1 when the scaled operand is the second one
    logic sign_a;
    logic sign_b;
    logic both_zero;
  } sdc_ctrl_t;

endpackage

`default_nettype wire

>>> src/sdc_prep.sv
// ----------------------------------------------------------------------------
// sdc_prep
// Input stage: masks mantissas, saturates scales, picks the operand that is
// brought up to the larger scale and registers the aligned pair.
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_prep import sdc_pkg::*; #(
  parameter int MANT_BITS = 96,
  parameter int MAX_SCALE = 28,
  parameter int WW        = MANT_BITS + 4 * MAX_SCALE,
  parameter int DW        = $clog2(MAX_SCALE + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 sign_a,
  input  wire logic [4:0]           scale_a,
  input  wire logic [95:0]          mant_a,
  input  wire logic                 sign_b,
  input  wire logic [4:0]           scale_b,
  input  wire logic [95:0]          mant_b,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [WW-1:0]             out_x,
  output logic [MANT_BITS-1:0]      out_y,
  output logic [DW-1:0]             out_diff,
  output sdc_ctrl_t                 out_ctrl
);

  localparam logic [5:0] MaxScale6 = 6'(MAX_SCALE);

  logic [MANT_BITS+95:0] ext_a, ext_b;
  logic [MANT_BITS-1:0]  ma, mb;
  logic [5:0]            ea6, eb6;
  logic [DW-1:0]         ea, eb;
  logic                  a_smaller;

  // Bits at or above MANT_BITS are dropped; narrower ports are zero-extended.
  assign ext_a = {{MANT_BITS{1'b0}}, mant_a};
  assign ext_b = {{MANT_BITS{1'b0}}, mant_b};
  assign ma    = ext_a[MANT_BITS-1:0];
  assign mb    = ext_b[MANT_BITS-1:0];

  assign ea6 = ({1'b0, scale_a} > MaxScale6) ? MaxScale6 : {1'b0, scale_a};
  assign eb6 = ({1'b0, scale_b} > MaxScale6) ? MaxScale6 : {1'b0, scale_b};
  assign ea  = ea6[DW-1:0];
  assign eb  = eb6[DW-1:0];

  assign a_smaller = (ea < eb);
  assign in_ready  = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      out_x              <= a_smaller ? WW'(ma) : WW'(mb);
      out_y              <= a_smaller ? mb : ma;
      out_diff           <= a_smaller ? DW'(eb - ea) : DW'(ea - eb);
      out_ctrl.swap      <= ~a_smaller;
      out_ctrl.sign_a    <= sign_a;
      out_ctrl.sign_b    <= sign_b;
      out_ctrl.both_zero <= (ma == '0) && (mb == '0);
    end
  end

endmodule

`default_nettype wire

>>> src/sdc_mul10_stage.sv
// ----------------------------------------------------------------------------
// sdc_mul10_stage
// One step of the power-of-ten alignment: multiplies the scaled operand by
// ten when this step is below the scale difference, then registers it.
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_mul10_stage import sdc_pkg::*; #(
  parameter int MANT_BITS = 96,
  parameter int WW        = 208,
  parameter int DW        = 5,
  parameter int STEP      = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [WW-1:0]        in_x,
  input  wire logic [MANT_BITS-1:0] in_y,
  input  wire logic [DW-1:0]        in_diff,
  input  wire sdc_ctrl_t            in_ctrl,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [WW-1:0]             out_x,
  output logic [MANT_BITS-1:0]      out_y,
  output logic [DW-1:0]             out_diff,
  output sdc_ctrl_t                 out_ctrl
);

  localparam logic [DW-1:0] Step = DW'(STEP);

  logic [WW-1:0] x_next;

  // x * 10 = x * 8 + x * 2; the width leaves four bits per decade, so no carry
  // is ever lost.
  assign x_next   = (Step < in_diff) ? ((in_x << 3) + (in_x << 1)) : in_x;
  assign in_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      out_x    <= x_next;
      out_y    <= in_y;
      out_diff <= in_diff;
      out_ctrl <= in_ctrl;
    end
  end

endmodule

`default_nettype wire

>>> src/sdc_cmp.sv
// ----------------------------------------------------------------------------
// sdc_cmp
// Final stage: compares the aligned magnitudes, applies the sign rules and
// holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_cmp import sdc_pkg::*; #(
  parameter int MANT_BITS = 96,
  parameter int WW        = 208
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [WW-1:0]        in_x,
  input  wire logic [MANT_BITS-1:0] in_y,
  input  wire sdc_ctrl_t            in_ctrl,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                order,
  output logic                      is_less,
  output logic                      is_equal,
  output logic                      is_greater
);

  logic [WW-1:0] mag_a, mag_b;
  logic          mag_gt, mag_lt;
  logic [1:0]    order_next;

  assign mag_a  = in_ctrl.swap ? WW'(in_y) : in_x;
  assign mag_b  = in_ctrl.swap ? in_x : WW'(in_y);
  assign mag_gt = (mag_a > mag_b);
  assign mag_lt = (mag_a < mag_b);

  always_comb begin
    if (in_ctrl.both_zero) begin
      order_next = ORD_EQUAL;
    end else if (in_ctrl.sign_a && !in_ctrl.sign_b) begin
      order_next = ORD_LESS;
    end else if (!in_ctrl.sign_a && in_ctrl.sign_b) begin
      order_next = ORD_GREATER;
    end else if (mag_gt) begin
      // Two negatives reverse the magnitude order.
      order_next = in_ctrl.sign_a ? ORD_LESS : ORD_GREATER;
    end else if (mag_lt) begin
      order_next = in_ctrl.sign_a ? ORD_GREATER : ORD_LESS;
    end else begin
      order_next = ORD_EQUAL;
    end
  end

  assign in_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      order      <= order_next;
      is_less    <= (order_next == ORD_LESS);
      is_equal   <= (order_next == ORD_EQUAL);
      is_greater <= (order_next == ORD_GREATER);
    end
  end

endmodule

`default_nettype wire

>>> src/scaled_decimal_compare.sv
// Each beat is registered in sdc_prep, in each alignment stage and in sdc_cmp.
// Throughput: one operand pair per cycle when m_tready does not stall it;
// the alignment chain has one multiply-by-ten stage per decade of MAX_SCALE,
// each a single wide add. Every stage holds its beat under backpressure, so
// input is taken while later stages are stalled as long as a stage has room.
// Reset clears only the stage valid bits; no data is cleared.
// ----------------------------------------------------------------------------
// scaled_decimal_compare
// Orders two sign-magnitude scaled decimals through a pipelined alignment.
// ----------------------------------------------------------------------------
`default_nettype none

module scaled_decimal_compare import sdc_pkg::*; #(
  parameter int MANT_BITS = 96,
  parameter int MAX_SCALE = 28
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // sign_a[0], scale_a[5:1], mant_a_low[69:6], mant_a_high[101:70],
  // sign_b[102], scale_b[107:103], mant_b_low[171:108], mant_b_high[203:172]
  input  wire logic [207:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // order[1:0], is_less[2], is_equal[3], is_greater[4]
  output logic [7:0]        m_tdata
);

  localparam int WW = MANT_BITS + 4 * MAX_SCALE;
  localparam int DW = $clog2(MAX_SCALE + 1);

  logic                 vld  [0:MAX_SCALE];
  logic                 rdy  [0:MAX_SCALE];
  logic [WW-1:0]        px   [0:MAX_SCALE];
  logic [MANT_BITS-1:0] py   [0:MAX_SCALE];
  logic [DW-1:0]        pd   [0:MAX_SCALE];
  sdc_ctrl_t            pc   [0:MAX_SCALE];

  logic                 cmp_ready;
  logic [1:0]           order;
  logic                 is_less, is_equal, is_greater;

  sdc_prep #(
    .MANT_BITS (MANT_BITS),
    .MAX_SCALE (MAX_SCALE),
    .WW        (WW),
    .DW        (DW)
  ) u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .sign_a    (s_tdata[0]),
    .scale_a   (s_tdata[5:1]),
    .mant_a    (s_tdata[101:6]),
    .sign_b    (s_tdata[102]),
    .scale_b   (s_tdata[107:103]),
    .mant_b    (s_tdata[203:108]),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_x     (px[0]),
    .out_y     (py[0]),
    .out_diff  (pd[0]),
    .out_ctrl  (pc[0])
  );

  for (genvar k = 0; k < MAX_SCALE; k++) begin : g_align
    sdc_mul10_stage #(
      .MANT_BITS (MANT_BITS),
      .WW        (WW),
      .DW        (DW),
      .STEP      (k)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[k]),
      .in_ready  (rdy[k]),
      .in_x      (px[k]),
      .in_y      (py[k]),
      .in_diff   (pd[k]),
      .in_ctrl   (pc[k]),
      .out_valid (vld[k+1]),
      .out_ready (rdy[k+1]),
      .out_x     (px[k+1]),
      .out_y     (py[k+1]),
      .out_diff  (pd[k+1]),
      .out_ctrl  (pc[k+1])
    );
  end

  // The compare only sees a valid beat when the last stage's difference is at most MAX_SCALE.
  assign rdy[MAX_SCALE] = cmp_ready;

  sdc_cmp #(
    .MANT_BITS (MANT_BITS),
    .WW        (WW)
  ) u_cmp (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (vld[MAX_SCALE] && (pd[MAX_SCALE] <= DW'(MAX_SCALE))),
    .in_ready   (cmp_ready),
    .in_x       (px[MAX_SCALE]),
    .in_y       (py[MAX_SCALE]),
    .in_ctrl    (pc[MAX_SCALE]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .order      (order),
    .is_less    (is_less),
    .is_equal   (is_equal),
    .is_greater (is_greater)
  );

  assign m_tdata = {3'b000, is_greater, is_equal, is_less, order};

`ifndef SYNTHESIS
  a_flags_onehot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot(m_tdata[4:2]))
    else $error("result flags are not one-hot");

  a_order_matches: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[1:0] == ORD_LESS) == m_tdata[2]) &&
                 ((m_tdata[1:0] == ORD_EQUAL) == m_tdata[3]) &&
                 ((m_tdata[1:0] == ORD_GREATER) == m_tdata[4]))
    else $error("order field disagrees with flags");

  a_empty_output_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty output register");
`endif

endmodule

`default_nettype wire
